>>> rtl/core/huff_pkg.sv
// Shared types and constants of the Huffman code builder.
package huff_pkg;

  localparam int CmdW     = 2;
  localparam int ByteW    = 8;
  localparam int CountW   = 16;
  localparam int LenW     = 5;
  localparam int CodeW    = 24;
  localparam int TbitsW   = 21;
  localparam int StatusW  = 2;

  // Command codes
  localparam logic [CmdW-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CmdW-1:0] CMD_ADD   = 2'd1;
  localparam logic [CmdW-1:0] CMD_BUILD = 2'd2;
  localparam logic [CmdW-1:0] CMD_READ  = 2'd3;

  // Status codes
  localparam logic [StatusW-1:0] ST_OK     = 2'd0;
  localparam logic [StatusW-1:0] ST_ABSENT = 2'd1;
  localparam logic [StatusW-1:0] ST_SAT    = 2'd2;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [ByteW-1:0] byte_value;
  } in_t;

  typedef struct packed {
    logic [ByteW-1:0]   symbol;
    logic [CountW-1:0]  symbol_count;
    logic [LenW-1:0]    code_length;
    logic [CodeW-1:0]   code_bits;
    logic [TbitsW-1:0]  total_bits;
    logic [CountW-1:0]  total_count;
    logic [StatusW-1:0] status;
  } out_t;

endpackage

>>> rtl/core/huff_ram.sv
// Generic single-write, single-read RAM with registered read data.
module huff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/huffman_code_builder.sv
// Top level of the Huffman code builder: histogram, tree sequencer and code table.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------
//   input   | in        | in_valid_i/in_stall_o  | in_t  (command, byte_value)
//   output  | out       | out_valid_o/out_stall_i| out_t (one per build/read)
//
// Steps: clear acts in the idle state, add updates the count in S_ADD, read
// forms its result in S_RD and waits for the output in S_PUSH. Build reads
// and writes each leaf in turn, then for each merge runs two linear scans
// over the node RAM, skipping dead nodes (issue, compare, drop the winner,
// one compare unit), and writes the new node and both parent links, then
// walks the code of each symbol, a present one level by level, and hands the result over.
// Reset: asynchronous, active low; histogram valid bits, flags and the
// sequencer clear at once, RAM contents need no clearing pass.
// Stalls: a new request is taken while a finished result waits in the
// output register; a second result waits in the sequencer until it drains.
module huffman_code_builder
  import huff_pkg::*;
#(
  parameter int SYMBOLS      = 256,
  parameter int COUNT_BITS   = 16,
  parameter int MAX_CODE_LEN = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int SBITS = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int NODES = 2 * SYMBOLS - 1;
  localparam int NBITS = $clog2(NODES);
  localparam int WBITS = COUNT_BITS + SBITS;
  localparam int HVN   = 1 << SBITS;
  localparam int PW    = COUNT_BITS + NBITS;

  // Sequencer states
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_ADD     = 5'd1;
  localparam logic [4:0] S_RD      = 5'd2;
  localparam logic [4:0] S_PUSH    = 5'd3;
  localparam logic [4:0] S_INIT_RD = 5'd4;
  localparam logic [4:0] S_INIT_WR = 5'd5;
  localparam logic [4:0] S_SCAN    = 5'd6;
  localparam logic [4:0] S_TAKE    = 5'd7;
  localparam logic [4:0] S_MERGE   = 5'd8;
  localparam logic [4:0] S_PAR_B   = 5'd9;
  localparam logic [4:0] S_W_RD    = 5'd10;
  localparam logic [4:0] S_W_HC    = 5'd11;
  localparam logic [4:0] S_W_STEP  = 5'd12;
  localparam logic [4:0] S_W_PB    = 5'd13;
  localparam logic [4:0] S_W_STORE = 5'd14;
  localparam logic [4:0] S_W_ACC   = 5'd15;
  localparam logic [4:0] S_BDONE   = 5'd16;

  // Control state
  logic [4:0]     state_q, state_d;
  logic           out_valid_q, out_valid_d;
  logic [HVN-1:0] hv_q, hv_d;
  logic           sat_q, sat_d;
  logic           ready_q, ready_d;
  logic           sv_q, sv_d;

  // Working registers
  logic [ByteW-1:0]      sym_q, sym_d;
  logic [SBITS-1:0]      s_q, s_d;
  logic [NBITS-1:0]      j_q, j_d;
  logic [NBITS-1:0]      sidx_q, sidx_d;
  logic                  found_q, found_d;
  logic [NBITS-1:0]      best_q, best_d;
  logic [WBITS-1:0]      bestw_q, bestw_d;
  logic                  pick_q, pick_d;
  logic [NBITS-1:0]      a_q, a_d;
  logic [WBITS-1:0]      aw_q, aw_d;
  logic [NBITS-1:0]      b_q, b_d;
  logic [WBITS-1:0]      bw_q, bw_d;
  logic [NBITS-1:0]      next_q, next_d;
  logic [SBITS:0]        live_q, live_d;
  logic [NBITS-1:0]      root_q, root_d;
  logic [NBITS-1:0]      nd_q, nd_d;
  logic [NBITS-1:0]      len_q, len_d;
  logic [CodeW-1:0]      word_q, word_d;
  logic [COUNT_BITS-1:0] hc_q, hc_d;
  logic [PW-1:0]         prod_q, prod_d;
  logic [TbitsW-1:0]     tb_q, tb_d;
  logic [CountW-1:0]     tc_q, tc_d;
  logic                  toolong_q, toolong_d;
  out_t                  res_q, res_d;
  out_t                  out_q, out_d;
  logic                  hrv_q;

  // RAM ports
  logic                   hist_we;
  logic [SBITS-1:0]       hist_waddr, hist_raddr;
  logic [COUNT_BITS-1:0]  hist_wdata, hist_rdata;
  logic                   wl_we;
  logic [NBITS-1:0]       wl_waddr;
  logic [WBITS:0]         wl_wdata, wl_rdata;
  logic                   pb_we;
  logic [NBITS-1:0]       pb_waddr;
  logic [NBITS:0]         pb_wdata, pb_rdata;
  logic                   code_we;
  logic [LenW+CodeW-1:0]  code_wdata, code_rdata;

  logic                  in_acc;
  logic [COUNT_BITS-1:0] hist_val;
  logic [31:0]           hist32;
  logic [CountW-1:0]     cnt_sat;
  logic [32:0]           tc_sum;
  logic [33:0]           tb_sum;
  logic                  push_ok;
  logic                  in_range;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign hist_val = hrv_q ? hist_rdata : '0;
  assign hist32   = 32'(hist_val);
  assign cnt_sat  = (hist32 > 32'hFFFF) ? 16'hFFFF : hist32[15:0];
  assign tc_sum   = 33'(tc_q) + 33'(hist_val);
  assign tb_sum   = 34'(tb_q) + 34'(prod_q);
  assign push_ok  = !out_valid_q || !out_stall_i;
  assign in_range = (9'(sym_q) < 9'(SYMBOLS));

  // Read address of the histogram: the request byte when idle, else the sweep
  assign hist_raddr = (state_q == S_IDLE) ? in_data_i.byte_value[SBITS-1:0] : s_q;

  huff_ram #(.WIDTH(COUNT_BITS), .DEPTH(SYMBOLS)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  // Node weight plus live flag
  huff_ram #(.WIDTH(WBITS + 1), .DEPTH(NODES)) u_wl_ram (
    .clk_i   (clk_i),
    .we_i    (wl_we),
    .waddr_i (wl_waddr),
    .wdata_i (wl_wdata),
    .raddr_i (j_q),
    .rdata_o (wl_rdata)
  );

  // Node parent plus branch bit
  huff_ram #(.WIDTH(NBITS + 1), .DEPTH(NODES)) u_pb_ram (
    .clk_i   (clk_i),
    .we_i    (pb_we),
    .waddr_i (pb_waddr),
    .wdata_i (pb_wdata),
    .raddr_i (nd_q),
    .rdata_o (pb_rdata)
  );

  // Code length plus code word per symbol
  huff_ram #(.WIDTH(LenW + CodeW), .DEPTH(SYMBOLS)) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (code_we),
    .waddr_i (s_q),
    .wdata_i (code_wdata),
    .raddr_i (in_data_i.byte_value[SBITS-1:0]),
    .rdata_o (code_rdata)
  );

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    hv_d        = hv_q;
    sat_d       = sat_q;
    ready_d     = ready_q;
    sv_d        = sv_q;
    sym_d       = sym_q;
    s_d         = s_q;
    j_d         = j_q;
    sidx_d      = sidx_q;
    found_d     = found_q;
    best_d      = best_q;
    bestw_d     = bestw_q;
    pick_d      = pick_q;
    a_d         = a_q;
    aw_d        = aw_q;
    b_d         = b_q;
    bw_d        = bw_q;
    next_d      = next_q;
    live_d      = live_q;
    root_d      = root_q;
    nd_d        = nd_q;
    len_d       = len_q;
    word_d      = word_q;
    hc_d        = hc_q;
    prod_d      = prod_q;
    tb_d        = tb_q;
    tc_d        = tc_q;
    toolong_d   = toolong_q;
    res_d       = res_q;
    out_d       = out_q;

    hist_we    = 1'b0;
    hist_waddr = sym_q[SBITS-1:0];
    hist_wdata = hist_val + COUNT_BITS'(1);
    wl_we      = 1'b0;
    wl_waddr   = best_q;
    wl_wdata   = {1'b0, bestw_q};
    pb_we      = 1'b0;
    pb_waddr   = a_q;
    pb_wdata   = {next_q, 1'b0};
    code_we    = 1'b0;
    code_wdata = {LenW'(len_q), word_q};

    // Drain the output register
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          sym_d = in_data_i.byte_value;
          unique case (in_data_i.command)
            CMD_CLEAR: begin
              hv_d    = '0;
              sat_d   = 1'b0;
              ready_d = 1'b0;
            end
            CMD_ADD: begin
              if (9'(in_data_i.byte_value) < 9'(SYMBOLS)) begin
                state_d = S_ADD;
              end
            end
            CMD_BUILD: begin
              s_d       = '0;
              live_d    = '0;
              tc_d      = '0;
              tb_d      = '0;
              toolong_d = 1'b0;
              next_d    = NBITS'(SYMBOLS);
              state_d   = S_INIT_RD;
            end
            CMD_READ: begin
              state_d = S_RD;
            end
            default: ;
          endcase
        end
      end

      S_ADD: begin
        // Hold a full count and flag it, else bump it
        ready_d = 1'b0;
        if (hist_val == {COUNT_BITS{1'b1}}) begin
          sat_d = 1'b1;
        end else begin
          hist_we                    = 1'b1;
          hv_d[sym_q[SBITS-1:0]]     = 1'b1;
        end
        state_d = S_IDLE;
      end

      S_RD: begin
        res_d        = '0;
        res_d.symbol = sym_q;
        res_d.status = ST_ABSENT;
        if (in_range) begin
          res_d.symbol_count = cnt_sat;
          if (ready_q && (hist_val != '0)) begin
            res_d.code_length = code_rdata[LenW+CodeW-1:CodeW];
            res_d.code_bits   = code_rdata[CodeW-1:0];
            res_d.status      = sat_q ? ST_SAT : ST_OK;
          end
        end
        state_d = S_PUSH;
      end

      S_PUSH: begin
        if (push_ok) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      S_INIT_RD: begin
        state_d = S_INIT_WR;
      end

      S_INIT_WR: begin
        // Load one leaf and fold its count into the totals
        wl_we    = 1'b1;
        wl_waddr = NBITS'(s_q);
        wl_wdata = {(hist_val != '0), WBITS'(hist_val)};
        tc_d     = (tc_sum > 33'hFFFF) ? 16'hFFFF : tc_sum[15:0];
        if (hist_val != '0) begin
          live_d = live_q + (SBITS+1)'(1);
          root_d = NBITS'(s_q);
        end
        if (s_q == SBITS'(SYMBOLS - 1)) begin
          s_d = '0;
          if (live_d > (SBITS+1)'(1)) begin
            j_d     = '0;
            sv_d    = 1'b0;
            found_d = 1'b0;
            pick_d  = 1'b0;
            state_d = S_SCAN;
          end else begin
            state_d = S_W_RD;
          end
        end else begin
          s_d     = s_q + SBITS'(1);
          state_d = S_INIT_RD;
        end
      end

      S_SCAN: begin
        // Issue one node address a cycle, compare the one read last cycle
        if (j_q != next_q) begin
          j_d = j_q + NBITS'(1);
        end
        sv_d   = (j_q != next_q);
        sidx_d = j_q;
        if (sv_q && wl_rdata[WBITS] &&
            (!found_q || (wl_rdata[WBITS-1:0] < bestw_q))) begin
          found_d = 1'b1;
          best_d  = sidx_q;
          bestw_d = wl_rdata[WBITS-1:0];
        end
        if ((j_q == next_q) && !sv_q) begin
          state_d = S_TAKE;
        end
      end

      S_TAKE: begin
        // Drop the winner from the live set
        wl_we    = 1'b1;
        wl_waddr = best_q;
        wl_wdata = {1'b0, bestw_q};
        if (!pick_q) begin
          a_d     = best_q;
          aw_d    = bestw_q;
          pick_d  = 1'b1;
          j_d     = '0;
          sv_d    = 1'b0;
          found_d = 1'b0;
          state_d = S_SCAN;
        end else begin
          b_d     = best_q;
          bw_d    = bestw_q;
          state_d = S_MERGE;
        end
      end

      S_MERGE: begin
        wl_we    = 1'b1;
        wl_waddr = next_q;
        wl_wdata = {1'b1, aw_q + bw_q};
        pb_we    = 1'b1;
        pb_waddr = a_q;
        pb_wdata = {next_q, 1'b0};
        state_d  = S_PAR_B;
      end

      S_PAR_B: begin
        pb_we    = 1'b1;
        pb_waddr = b_q;
        pb_wdata = {next_q, 1'b1};
        root_d   = next_q;
        next_d   = next_q + NBITS'(1);
        live_d   = live_q - (SBITS+1)'(1);
        if (live_d > (SBITS+1)'(1)) begin
          j_d     = '0;
          sv_d    = 1'b0;
          found_d = 1'b0;
          pick_d  = 1'b0;
          state_d = S_SCAN;
        end else begin
          s_d     = '0;
          state_d = S_W_RD;
        end
      end

      S_W_RD: begin
        state_d = S_W_HC;
      end

      S_W_HC: begin
        hc_d   = hist_val;
        nd_d   = NBITS'(s_q);
        len_d  = '0;
        word_d = '0;
        state_d = (hist_val == '0) ? S_W_STORE : S_W_STEP;
      end

      S_W_STEP: begin
        state_d = (nd_q == root_q) ? S_W_STORE : S_W_PB;
      end

      S_W_PB: begin
        // Climb one level; the branch bit lands at the current depth
        if (pb_rdata[0] && (int'(len_q) < CodeW)) begin
          word_d[5'(len_q)] = 1'b1;
        end
        len_d   = len_q + NBITS'(1);
        nd_d    = pb_rdata[NBITS:1];
        state_d = S_W_STEP;
      end

      S_W_STORE: begin
        code_we = 1'b1;
        if (int'(len_q) > MAX_CODE_LEN) begin
          toolong_d = 1'b1;
        end
        prod_d  = PW'(hc_q) * PW'(len_q);
        state_d = S_W_ACC;
      end

      S_W_ACC: begin
        tb_d = (tb_sum > 34'h1FFFFF) ? 21'h1FFFFF : tb_sum[20:0];
        if (s_q == SBITS'(SYMBOLS - 1)) begin
          state_d = S_BDONE;
        end else begin
          s_d     = s_q + SBITS'(1);
          state_d = S_W_RD;
        end
      end

      S_BDONE: begin
        res_d             = '0;
        res_d.total_bits  = tb_q;
        res_d.total_count = tc_q;
        res_d.status      = toolong_q ? ST_ABSENT : (sat_q ? ST_SAT : ST_OK);
        ready_d           = !toolong_q;
        state_d           = S_PUSH;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      hv_q        <= '0;
      sat_q       <= 1'b0;
      ready_q     <= 1'b0;
      sv_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      hv_q        <= hv_d;
      sat_q       <= sat_d;
      ready_q     <= ready_d;
      sv_q        <= sv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q     <= sym_d;
    s_q       <= s_d;
    j_q       <= j_d;
    sidx_q    <= sidx_d;
    found_q   <= found_d;
    best_q    <= best_d;
    bestw_q   <= bestw_d;
    pick_q    <= pick_d;
    a_q       <= a_d;
    aw_q      <= aw_d;
    b_q       <= b_d;
    bw_q      <= bw_d;
    next_q    <= next_d;
    live_q    <= live_d;
    root_q    <= root_d;
    nd_q      <= nd_d;
    len_q     <= len_d;
    word_q    <= word_d;
    hc_q      <= hc_d;
    prod_q    <= prod_d;
    tb_q      <= tb_d;
    tc_q      <= tc_d;
    toolong_q <= toolong_d;
    res_q     <= res_d;
    out_q     <= out_d;
    hrv_q     <= hv_q[hist_raddr];
  end

  // The scan pointer never runs past the newest node
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (j_q <= next_q))
    else $error("scan pointer beyond node count");

  // A merge joins two distinct nodes while at least two are live
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MERGE) |-> ((a_q != b_q) && (live_q > (SBITS+1)'(1))))
    else $error("bad merge operands");

  // A clear request empties the histogram by the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_data_i.command == CMD_CLEAR)) |=> ((hv_q == '0) && !ready_q))
    else $error("clear did not empty histogram");

  // A pending result is pushed only into a free output slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && (state_q == S_PUSH)) |=> (state_q == S_PUSH))
    else $error("result pushed over a stalled output");

endmodule
